>>> rtl/core/cblm_pkg.sv
package cblm_pkg;

	// field and register widths
	localparam int FUNC_W      = 2;
	localparam int FBITS_W     = 10;
	localparam int PLEN_W      = 7;
	localparam int LOAD_W      = 10;
	localparam int FRAME_CNT_W = 16;
	localparam int BIT_CNT_W   = 24;
	localparam int DIR_W       = 2;
	localparam int NOM_BR_W    = 20;
	localparam int DATA_BR_W   = 23;
	localparam int CFG_W       = 23;
	localparam int CFG_IDX_W   = 2;

	localparam logic [LOAD_W-1:0] PCT_CEIL = '1;

	// payload bytes to bits
	localparam int BYTE_SHIFT = 3;

	// load percent divisions
	localparam int PCT_SCALE   = 100;
	localparam int PCT_SCALE_W = 7;
	localparam int DIVIDEND_W  = BIT_CNT_W + PCT_SCALE_W;
	localparam int DIVISOR_W   = DATA_BR_W;
	localparam int DIV_STEPS   = DIVIDEND_W;
	localparam int STEP_CNT_W  = $clog2(DIV_STEPS + 1);

	// moving averages
	localparam int FRACTION_BITS = 12;
	localparam int Q12_BITS      = 12;
	localparam int AVG_W         = LOAD_W + FRACTION_BITS;
	localparam int EMA_LANES     = 3;
	localparam int LANE_W        = 2;
	localparam int ONE           = 1 << FRACTION_BITS;
	localparam int HALF          = 1 << (FRACTION_BITS - 1);
	localparam int Q12_DECAY_1M  = 4028;
	localparam int Q12_DECAY_5M  = 4082;
	localparam int Q12_DECAY_15M = 4091;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_FRAME     = 2'd0,
		FUNC_TICK      = 2'd1,
		FUNC_STATS_RST = 2'd2
	} cblm_func_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NOMINAL_BR = 2'd0,
		REG_DATA_BR    = 2'd1,
		REG_STATS_EN   = 2'd2
	} cblm_reg_t;

	localparam logic [DIR_W-1:0] DIR_RX = 2'b01;
	localparam logic [DIR_W-1:0] DIR_TX = 2'b10;

	// controller to datapath
	typedef struct packed {
		logic frame_add;
		logic stats_req;
		logic div_start;
		logic pct_load;
		logic ema_mul;
		logic stats_upd;
		logic out_load;
	} cblm_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic div_done;
		logic div_busy;
		logic out_free;
	} cblm_sts_t;

	// decay factor of one averaging lane, rescaled to FRACTION_BITS
	function automatic logic [FRACTION_BITS-1:0] ema_decay(input logic [LANE_W-1:0] lane);
		int q12;
		unique case (lane)
			2'd0:    q12 = Q12_DECAY_1M;
			2'd1:    q12 = Q12_DECAY_5M;
			default: q12 = Q12_DECAY_15M;
		endcase
		return FRACTION_BITS'((q12 << FRACTION_BITS) >> Q12_BITS);
	endfunction

	// weight of the new sample: one minus decay
	function automatic logic [FRACTION_BITS-1:0] ema_gain(input logic [LANE_W-1:0] lane);
		int d;
		d = int'(ema_decay(lane));
		return FRACTION_BITS'(ONE - d);
	endfunction

endpackage

>>> rtl/core/cblm_in_if.sv
interface cblm_in_if;
	logic                            valid;
	logic                            ready;
	logic [cblm_pkg::FUNC_W-1:0]     func;
	logic [cblm_pkg::FBITS_W-1:0]    frame_bits;
	logic [cblm_pkg::FBITS_W-1:0]    data_phase_bits;
	logic [cblm_pkg::PLEN_W-1:0]     payload_len;
	logic                            is_tx;

	modport source(output valid, func, frame_bits, data_phase_bits, payload_len, is_tx,
		input ready);
	modport sink(input valid, func, frame_bits, data_phase_bits, payload_len, is_tx,
		output ready);
endinterface

>>> rtl/core/cblm_out_if.sv
interface cblm_out_if;
	logic                               valid;
	logic                               ready;
	logic [cblm_pkg::LOAD_W-1:0]        load_percent;
	logic [cblm_pkg::FRAME_CNT_W-1:0]   frame_count;
	logic [cblm_pkg::BIT_CNT_W-1:0]     total_bits;
	logic [cblm_pkg::BIT_CNT_W-1:0]     payload_bits;
	logic [cblm_pkg::BIT_CNT_W-1:0]     data_bits;
	logic [cblm_pkg::DIR_W-1:0]         direction;
	logic [cblm_pkg::LOAD_W-1:0]        load_minimum;
	logic [cblm_pkg::LOAD_W-1:0]        load_maximum;
	logic [cblm_pkg::LOAD_W-1:0]        average_1m;
	logic [cblm_pkg::LOAD_W-1:0]        average_5m;
	logic [cblm_pkg::LOAD_W-1:0]        average_15m;

	modport source(output valid, load_percent, frame_count, total_bits, payload_bits,
		data_bits, direction, load_minimum, load_maximum, average_1m, average_5m,
		average_15m, input ready);
	modport sink(input valid, load_percent, frame_count, total_bits, payload_bits,
		data_bits, direction, load_minimum, load_maximum, average_1m, average_5m,
		average_15m, output ready);
endinterface

>>> rtl/core/cblm_div.sv
// restoring divider, one quotient bit per cycle
module cblm_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [cblm_pkg::DIVIDEND_W-1:0]   dividend,
	input  logic [cblm_pkg::DIVISOR_W-1:0]    divisor,
	output logic                              busy,
	output logic                              done,
	output logic [cblm_pkg::DIVIDEND_W-1:0]   quotient
);

	logic                               busy_q;
	logic [cblm_pkg::STEP_CNT_W-1:0]    cnt_q;
	logic [cblm_pkg::DIVIDEND_W-1:0]    quo_q;
	logic [cblm_pkg::DIVISOR_W-1:0]     rem_q;
	logic [cblm_pkg::DIVISOR_W-1:0]     dsr_q;
	logic [cblm_pkg::DIVISOR_W:0]       trial;
	logic [cblm_pkg::DIVISOR_W:0]       diff;
	logic                               ge;

	// shift in next dividend bit, trial subtract
	always_comb begin
		trial = {rem_q, quo_q[cblm_pkg::DIVIDEND_W-1]};
		diff  = trial - {1'b0, dsr_q};
		ge    = trial >= {1'b0, dsr_q};
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= cblm_pkg::STEP_CNT_W'(cblm_pkg::DIV_STEPS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - cblm_pkg::STEP_CNT_W'(1);
			if (cnt_q == cblm_pkg::STEP_CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[cblm_pkg::DIVISOR_W-1:0] : trial[cblm_pkg::DIVISOR_W-1:0];
			quo_q <= {quo_q[cblm_pkg::DIVIDEND_W-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign done     = busy_q && (cnt_q == cblm_pkg::STEP_CNT_W'(1));
	assign quotient = quo_q;

endmodule

>>> rtl/core/cblm_ctrl.sv
// sequencer: frame update, tick division, statistics, result hand-off
module cblm_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [cblm_pkg::FUNC_W-1:0]   in_func,
	input  cblm_pkg::cblm_sts_t           sts,
	output logic                          in_ready,
	output cblm_pkg::cblm_cmd_t           cmd
);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_DIV  = 6'b000010,
		S_PCT  = 6'b000100,
		S_MUL  = 6'b001000,
		S_UPD  = 6'b010000,
		S_OUT  = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = (state_q == S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					unique case (in_func)
						cblm_pkg::FUNC_FRAME:     cmd.frame_add = 1'b1;
						cblm_pkg::FUNC_STATS_RST: cmd.stats_req = 1'b1;
						cblm_pkg::FUNC_TICK: begin
							cmd.div_start = 1'b1;
							state_d       = S_DIV;
						end
						default: ;
					endcase
				end
			end
			S_DIV: begin
				if (sts.div_done) begin
					state_d = S_PCT;
				end
			end
			S_PCT: begin
				cmd.pct_load = 1'b1;
				state_d      = S_MUL;
			end
			S_MUL: begin
				cmd.ema_mul = 1'b1;
				state_d     = S_UPD;
			end
			S_UPD: begin
				cmd.stats_upd = 1'b1;
				state_d       = S_OUT;
			end
			S_OUT: begin
				// wait until the output register can take the word
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> rtl/core/cblm_dp.sv
// counters, config, load dividers, min/max, moving averages, result register
module cblm_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [cblm_pkg::CFG_IDX_W-1:0]    wr_index,
	input  logic [cblm_pkg::CFG_W-1:0]        wr_data,
	input  logic [cblm_pkg::FBITS_W-1:0]      frame_bits,
	input  logic [cblm_pkg::FBITS_W-1:0]      data_phase_bits,
	input  logic [cblm_pkg::PLEN_W-1:0]       payload_len,
	input  logic                              is_tx,
	input  cblm_pkg::cblm_cmd_t               cmd,
	output cblm_pkg::cblm_sts_t               sts,
	input  logic                              out_ready,
	output logic                              out_valid,
	output logic [cblm_pkg::LOAD_W-1:0]       load_percent,
	output logic [cblm_pkg::FRAME_CNT_W-1:0]  frame_count,
	output logic [cblm_pkg::BIT_CNT_W-1:0]    total_bits,
	output logic [cblm_pkg::BIT_CNT_W-1:0]    payload_bits,
	output logic [cblm_pkg::BIT_CNT_W-1:0]    data_bits,
	output logic [cblm_pkg::DIR_W-1:0]        direction,
	output logic [cblm_pkg::LOAD_W-1:0]       load_minimum,
	output logic [cblm_pkg::LOAD_W-1:0]       load_maximum,
	output logic [cblm_pkg::LOAD_W-1:0]       average_1m,
	output logic [cblm_pkg::LOAD_W-1:0]       average_5m,
	output logic [cblm_pkg::LOAD_W-1:0]       average_15m
);

	localparam int BW   = cblm_pkg::BIT_CNT_W;
	localparam int FB   = cblm_pkg::FRACTION_BITS;
	localparam int AW   = cblm_pkg::AVG_W;
	localparam int LW   = cblm_pkg::LOAD_W;
	localparam int NL   = cblm_pkg::EMA_LANES;
	localparam int DVW  = cblm_pkg::DIVIDEND_W;
	localparam int SUMW = AW + FB + 1;

	// config registers
	logic [cblm_pkg::NOM_BR_W-1:0]   nom_br_q;
	logic [cblm_pkg::DATA_BR_W-1:0]  data_br_q;
	logic                            stats_en_q;

	// per-second counters
	logic [cblm_pkg::FRAME_CNT_W-1:0] frame_cnt_q;
	logic [BW-1:0]                    total_cnt_q;
	logic [BW-1:0]                    pay_cnt_q;
	logic [BW-1:0]                    data_cnt_q;
	logic [cblm_pkg::DIR_W-1:0]       dir_q;
	logic                             pend_q;

	logic [cblm_pkg::FRAME_CNT_W:0]   frame_sum;
	logic [BW:0]                      total_sum;
	logic [BW:0]                      pay_sum;
	logic [BW:0]                      data_sum;

	// load divisions
	logic [BW-1:0]                    nom_bits;
	logic [DVW-1:0]                   nom_dividend;
	logic [DVW-1:0]                   data_dividend;
	logic [DVW-1:0]                   nom_quo;
	logic [DVW-1:0]                   data_quo;
	logic                             nom_busy;
	logic                             data_busy;
	logic                             nom_done;
	logic                             data_done;
	logic [DVW:0]                     pct_sum;
	logic [LW-1:0]                    pct_d;
	logic [LW-1:0]                    pct_q;

	// statistics
	logic [LW-1:0]                    min_q;
	logic [LW-1:0]                    max_q;
	logic [LW-1:0]                    min_eff;
	logic [LW-1:0]                    max_eff;
	logic [AW-1:0]                    avg_q       [NL];
	logic [AW+FB-1:0]                 prod_avg_s1 [NL];
	logic [LW+FB-1:0]                 prod_smp_s1 [NL];
	logic [SUMW-1:0]                  ema_sum     [NL];
	logic [AW:0]                      rnd_full    [NL];
	logic [LW:0]                      rnd_int     [NL];
	logic [LW-1:0]                    rnd_sat     [NL];

	// result register
	logic                             out_valid_q;
	logic [LW-1:0]                    out_pct_q;
	logic [cblm_pkg::FRAME_CNT_W-1:0] out_frames_q;
	logic [BW-1:0]                    out_total_q;
	logic [BW-1:0]                    out_pay_q;
	logic [BW-1:0]                    out_data_q;
	logic [cblm_pkg::DIR_W-1:0]       out_dir_q;
	logic [LW-1:0]                    out_min_q;
	logic [LW-1:0]                    out_max_q;
	logic [LW-1:0]                    out_avg_q   [NL];

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nom_br_q   <= cblm_pkg::NOM_BR_W'(500000);
			data_br_q  <= cblm_pkg::DATA_BR_W'(500000);
			stats_en_q <= 1'b0;
		end else if (wr_en) begin
			unique case (wr_index)
				cblm_pkg::REG_NOMINAL_BR: nom_br_q   <= wr_data[cblm_pkg::NOM_BR_W-1:0];
				cblm_pkg::REG_DATA_BR:    data_br_q  <= wr_data[cblm_pkg::DATA_BR_W-1:0];
				cblm_pkg::REG_STATS_EN:   stats_en_q <= wr_data[0];
				default: ;
			endcase
		end
	end

	// saturating counter sums
	always_comb begin
		frame_sum = {1'b0, frame_cnt_q} + (cblm_pkg::FRAME_CNT_W+1)'(1);
		total_sum = {1'b0, total_cnt_q} + (BW+1)'(frame_bits);
		pay_sum   = {1'b0, pay_cnt_q} + ((BW+1)'(payload_len) << cblm_pkg::BYTE_SHIFT);
		data_sum  = {1'b0, data_cnt_q} + (BW+1)'(data_phase_bits);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_cnt_q <= '0;
			total_cnt_q <= '0;
			pay_cnt_q   <= '0;
			data_cnt_q  <= '0;
			dir_q       <= '0;
			pend_q      <= 1'b1;
		end else if (cmd.out_load) begin
			frame_cnt_q <= '0;
			total_cnt_q <= '0;
			pay_cnt_q   <= '0;
			data_cnt_q  <= '0;
			dir_q       <= '0;
			pend_q      <= 1'b0;
		end else begin
			if (cmd.frame_add) begin
				frame_cnt_q <= frame_sum[cblm_pkg::FRAME_CNT_W] ? '1 :
					frame_sum[cblm_pkg::FRAME_CNT_W-1:0];
				total_cnt_q <= total_sum[BW] ? '1 : total_sum[BW-1:0];
				pay_cnt_q   <= pay_sum[BW] ? '1 : pay_sum[BW-1:0];
				data_cnt_q  <= data_sum[BW] ? '1 : data_sum[BW-1:0];
				dir_q       <= dir_q | (is_tx ? cblm_pkg::DIR_TX : cblm_pkg::DIR_RX);
			end
			if (cmd.stats_req) begin
				pend_q <= 1'b1;
			end
		end
	end

	// dividends: bits times 100, nominal bits floored at zero
	always_comb begin
		nom_bits      = (total_cnt_q >= data_cnt_q) ? total_cnt_q - data_cnt_q : '0;
		nom_dividend  = DVW'(nom_bits) * DVW'(cblm_pkg::PCT_SCALE);
		data_dividend = DVW'(data_cnt_q) * DVW'(cblm_pkg::PCT_SCALE);
	end

	cblm_div u_div_nom (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (nom_dividend),
		.divisor  (cblm_pkg::DIVISOR_W'(nom_br_q)),
		.busy     (nom_busy),
		.done     (nom_done),
		.quotient (nom_quo)
	);

	cblm_div u_div_data (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (data_dividend),
		.divisor  (data_br_q),
		.busy     (data_busy),
		.done     (data_done),
		.quotient (data_quo)
	);

	// load percent: zero nominal bitrate gives zero, zero data bitrate drops the data term, sum clipped at PCT_CEIL
	always_comb begin
		pct_sum = {1'b0, nom_quo} +
			{1'b0, (data_br_q != '0) ? data_quo : DVW'(0)};
		if (nom_br_q == '0) begin
			pct_d = '0;
		end else if (pct_sum > (DVW+1)'(cblm_pkg::PCT_CEIL)) begin
			pct_d = cblm_pkg::PCT_CEIL;
		end else begin
			pct_d = pct_sum[LW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pct_load) begin
			pct_q <= pct_d;
		end
	end

	// moving average products, pending reset starts lanes from zero
	always_ff @(posedge clk) begin
		if (cmd.ema_mul) begin
			for (int k = 0; k < NL; k++) begin
				prod_avg_s1[k] <= (AW+FB)'(pend_q ? '0 : avg_q[k]) *
					(AW+FB)'(cblm_pkg::ema_decay(cblm_pkg::LANE_W'(k)));
				prod_smp_s1[k] <= (LW+FB)'(pct_q) *
					(LW+FB)'(cblm_pkg::ema_gain(cblm_pkg::LANE_W'(k)));
			end
		end
	end

	// new average and rounded view per lane
	always_comb begin
		for (int k = 0; k < NL; k++) begin
			ema_sum[k]  = SUMW'(prod_avg_s1[k]) + (SUMW'(prod_smp_s1[k]) << FB);
			rnd_full[k] = (AW+1)'(avg_q[k]) + (AW+1)'(cblm_pkg::HALF);
			rnd_int[k]  = rnd_full[k][AW:FB];
			rnd_sat[k]  = (rnd_int[k] > (LW+1)'(cblm_pkg::PCT_CEIL)) ?
				cblm_pkg::PCT_CEIL : rnd_int[k][LW-1:0];
		end
		min_eff = pend_q ? cblm_pkg::PCT_CEIL : min_q;
		max_eff = pend_q ? LW'(0) : max_q;
	end

	// statistics update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= cblm_pkg::PCT_CEIL;
			max_q <= '0;
			for (int k = 0; k < NL; k++) begin
				avg_q[k] <= '0;
			end
		end else if (cmd.stats_upd && stats_en_q) begin
			min_q <= (pct_q < min_eff) ? pct_q : min_eff;
			max_q <= (pct_q > max_eff) ? pct_q : max_eff;
			for (int k = 0; k < NL; k++) begin
				avg_q[k] <= ema_sum[k][FB +: AW];
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_pct_q    <= pct_q;
			out_frames_q <= frame_cnt_q;
			out_total_q  <= total_cnt_q;
			out_pay_q    <= pay_cnt_q;
			out_data_q   <= data_cnt_q;
			out_dir_q    <= dir_q;
			out_min_q    <= stats_en_q ? min_q : LW'(0);
			out_max_q    <= stats_en_q ? max_q : LW'(0);
			for (int k = 0; k < NL; k++) begin
				out_avg_q[k] <= stats_en_q ? rnd_sat[k] : LW'(0);
			end
		end
	end

	assign sts.div_done = nom_done & data_done;
	assign sts.div_busy = nom_busy | data_busy;
	assign sts.out_free = !out_valid_q || out_ready;

	assign out_valid    = out_valid_q;
	assign load_percent = out_pct_q;
	assign frame_count  = out_frames_q;
	assign total_bits   = out_total_q;
	assign payload_bits = out_pay_q;
	assign data_bits    = out_data_q;
	assign direction    = out_dir_q;
	assign load_minimum = out_min_q;
	assign load_maximum = out_max_q;
	assign average_1m   = out_avg_q[0];
	assign average_5m   = out_avg_q[1];
	assign average_15m  = out_avg_q[2];

endmodule

>>> rtl/core/can_bus_load_monitor.sv
// Frame and statistics-reset words give no result.
// A tick word gives one result, set by two parallel 31-step bit-serial
// dividers followed by the load percent, average, statistics and output states;
// the next word is taken once the result is loaded, later if the result waits.
// arst_n clears counters and statistics and loads bitrates 500000/500000, stats off.
module can_bus_load_monitor (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [cblm_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [cblm_pkg::CFG_W-1:0]      wr_data,
	cblm_in_if.sink                         evt,
	cblm_out_if.source                      rpt
);

	cblm_pkg::cblm_cmd_t cmd;
	cblm_pkg::cblm_sts_t sts;
	logic                in_ready;

	cblm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (evt.valid),
		.in_func  (evt.func),
		.sts      (sts),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	cblm_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.wr_en           (wr_en),
		.wr_index        (wr_index),
		.wr_data         (wr_data),
		.frame_bits      (evt.frame_bits),
		.data_phase_bits (evt.data_phase_bits),
		.payload_len     (evt.payload_len),
		.is_tx           (evt.is_tx),
		.cmd             (cmd),
		.sts             (sts),
		.out_ready       (rpt.ready),
		.out_valid       (rpt.valid),
		.load_percent    (rpt.load_percent),
		.frame_count     (rpt.frame_count),
		.total_bits      (rpt.total_bits),
		.payload_bits    (rpt.payload_bits),
		.data_bits       (rpt.data_bits),
		.direction       (rpt.direction),
		.load_minimum    (rpt.load_minimum),
		.load_maximum    (rpt.load_maximum),
		.average_1m      (rpt.average_1m),
		.average_5m      (rpt.average_5m),
		.average_15m     (rpt.average_15m)
	);

	assign evt.ready = in_ready;

	// no new word while the dividers run
	a_ready_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		evt.ready |-> !sts.div_busy)
		else $error("input ready while divider busy");

	// result register is never overwritten while a word waits
	a_out_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("result loaded over a waiting word");

	// a tick blocks further input on the next cycle
	a_tick_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(evt.valid && evt.ready && (evt.func == cblm_pkg::FUNC_TICK)) |=> !evt.ready)
		else $error("input still ready after tick");

	// a loaded result shows up as valid
	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> rpt.valid)
		else $error("loaded result not valid");

endmodule

>>> sim/can_bus_load_monitor_tb.sv
module can_bus_load_monitor_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cblm_pkg::*;

	// code the block ignores
	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

	// a frame word leaves nothing to compare, so give the block this long before a write
	localparam int SETTLE_CYCLES  = 40;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int LONG_FRAMES    = 250;

	localparam logic [63:0] FRAMES_TOP = (64'd1 << FRAME_CNT_W) - 64'd1;
	localparam logic [63:0] BITS_TOP   = (64'd1 << BIT_CNT_W) - 64'd1;

	typedef struct {
		logic [FUNC_W-1:0]  func;
		logic [FBITS_W-1:0] frame_bits;
		logic [FBITS_W-1:0] data_phase_bits;
		logic [PLEN_W-1:0]  payload_len;
		logic               is_tx;
	} can_word_t;

	typedef struct {
		logic [LOAD_W-1:0]      load_percent;
		logic [FRAME_CNT_W-1:0] frame_count;
		logic [BIT_CNT_W-1:0]   total_bits;
		logic [BIT_CNT_W-1:0]   payload_bits;
		logic [BIT_CNT_W-1:0]   data_bits;
		logic [DIR_W-1:0]       direction;
		logic [LOAD_W-1:0]      load_minimum;
		logic [LOAD_W-1:0]      load_maximum;
		logic [LOAD_W-1:0]      average_1m;
		logic [LOAD_W-1:0]      average_5m;
		logic [LOAD_W-1:0]      average_15m;
	} load_report_t;

	logic                 clk;
	logic                 arst_n;
	logic                 wr_en;
	logic [CFG_IDX_W-1:0] wr_index;
	logic [CFG_W-1:0]     wr_data;

	cblm_in_if  evt();
	cblm_out_if rpt();

	can_bus_load_monitor dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.evt      (evt),
		.rpt      (rpt)
	);

	// predicted register and statistics state
	logic [NOM_BR_W-1:0]    nom_br;
	logic [DATA_BR_W-1:0]   data_br;
	logic                   stats_on;
	logic [FRAME_CNT_W-1:0] frames_acc;
	logic [BIT_CNT_W-1:0]   bits_acc;
	logic [BIT_CNT_W-1:0]   payload_acc;
	logic [BIT_CNT_W-1:0]   dbits_acc;
	logic [DIR_W-1:0]       dir_acc;
	logic                   stats_clear_pending;
	logic [LOAD_W-1:0]      min_load;
	logic [LOAD_W-1:0]      max_load;
	logic [63:0]            avg_lane [EMA_LANES];

	load_report_t pending_reports [$];

	int errors          = 0;
	int words_sent      = 0;
	int reports_checked = 0;
	int configs_applied = 0;
	int idle_cycles     = 0;
	int tx_idle_pct     = 7;
	int rx_idle_pct     = 67;

	// clock, 4 ns period
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// receiver back-pressure
	always @(posedge clk) begin
		rpt.ready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// ---------------------------------------------------------------- predictor

	function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b, logic [63:0] top);
		logic [63:0] s;
		s = a + b;
		return (s > top) ? top : s;
	endfunction

	// load of the finished second: nominal part plus data part, clipped
	function automatic logic [LOAD_W-1:0] load_of_second();
		logic [63:0] nom_bits;
		logic [63:0] pct;
		if (nom_br == '0)
			return '0;
		nom_bits = (bits_acc >= dbits_acc) ? 64'(bits_acc) - 64'(dbits_acc) : 64'd0;
		pct = (nom_bits * 64'(PCT_SCALE)) / 64'(nom_br);
		if (data_br != '0)
			pct = pct + (64'(dbits_acc) * 64'(PCT_SCALE)) / 64'(data_br);
		return (pct > 64'(PCT_CEIL)) ? PCT_CEIL : pct[LOAD_W-1:0];
	endfunction

	function automatic logic [63:0] ema_next(logic [63:0] avg, int q12, logic [LOAD_W-1:0] smp);
		logic [63:0] one;
		logic [63:0] dec;
		logic [63:0] scaled;
		one    = 64'd1 << FRACTION_BITS;
		dec    = (64'(q12) << FRACTION_BITS) >> Q12_BITS;
		scaled = 64'(smp) << FRACTION_BITS;
		return (avg * dec + scaled * (one - dec)) >> FRACTION_BITS;
	endfunction

	function automatic logic [LOAD_W-1:0] rounded_avg(logic [63:0] avg);
		logic [63:0] r;
		r = (avg + (64'd1 << (FRACTION_BITS - 1))) >> FRACTION_BITS;
		return (r > 64'(PCT_CEIL)) ? PCT_CEIL : r[LOAD_W-1:0];
	endfunction

	task automatic reset_prediction();
		nom_br              = NOM_BR_W'(500000);
		data_br             = DATA_BR_W'(500000);
		stats_on            = 1'b0;
		frames_acc          = '0;
		bits_acc            = '0;
		payload_acc         = '0;
		dbits_acc           = '0;
		dir_acc             = '0;
		stats_clear_pending = 1'b1;
		min_load            = PCT_CEIL;
		max_load            = '0;
		foreach (avg_lane[i])
			avg_lane[i] = 64'd0;
	endtask

	// update the predicted state for one accepted word
	task automatic predict_word(can_word_t w);
		load_report_t      r;
		logic [LOAD_W-1:0] pct;
		case (w.func)
			FUNC_FRAME: begin
				dir_acc     = dir_acc | (w.is_tx ? DIR_TX : DIR_RX);
				frames_acc  = FRAME_CNT_W'(sat_add(64'(frames_acc), 64'd1, FRAMES_TOP));
				bits_acc    = BIT_CNT_W'(sat_add(64'(bits_acc), 64'(w.frame_bits), BITS_TOP));
				payload_acc = BIT_CNT_W'(sat_add(64'(payload_acc),
					64'(w.payload_len) << BYTE_SHIFT, BITS_TOP));
				dbits_acc   = BIT_CNT_W'(sat_add(64'(dbits_acc), 64'(w.data_phase_bits),
					BITS_TOP));
			end
			FUNC_STATS_RST: begin
				stats_clear_pending = 1'b1;
			end
			FUNC_TICK: begin
				pct = load_of_second();
				r = '{default: '0};
				r.load_percent = pct;
				r.frame_count  = frames_acc;
				r.total_bits   = bits_acc;
				r.payload_bits = payload_acc;
				r.data_bits    = dbits_acc;
				r.direction    = dir_acc;
				if (stats_on) begin
					if (stats_clear_pending) begin
						min_load = PCT_CEIL;
						max_load = '0;
						foreach (avg_lane[i])
							avg_lane[i] = 64'd0;
					end
					if (pct < min_load)
						min_load = pct;
					if (pct > max_load)
						max_load = pct;
					avg_lane[0] = ema_next(avg_lane[0], Q12_DECAY_1M, pct);
					avg_lane[1] = ema_next(avg_lane[1], Q12_DECAY_5M, pct);
					avg_lane[2] = ema_next(avg_lane[2], Q12_DECAY_15M, pct);
					r.load_minimum = min_load;
					r.load_maximum = max_load;
					r.average_1m   = rounded_avg(avg_lane[0]);
					r.average_5m   = rounded_avg(avg_lane[1]);
					r.average_15m  = rounded_avg(avg_lane[2]);
				end
				stats_clear_pending = 1'b0;
				frames_acc  = '0;
				bits_acc    = '0;
				payload_acc = '0;
				dbits_acc   = '0;
				dir_acc     = '0;
				pending_reports.push_back(r);
			end
			default: ;
		endcase
	endtask

	// ---------------------------------------------------------------- checking

	function automatic void compare_field(string name, logic [BIT_CNT_W-1:0] want,
		logic [BIT_CNT_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin : check_reports
		load_report_t want;
		if (rpt.valid === 1'b1 && rpt.ready === 1'b1) begin
			if (pending_reports.size() == 0) begin
				$error("report word with no report expected");
				errors++;
			end else begin
				want = pending_reports.pop_front();
				compare_field("load_percent", want.load_percent, rpt.load_percent);
				compare_field("frame_count", want.frame_count, rpt.frame_count);
				compare_field("total_bits", want.total_bits, rpt.total_bits);
				compare_field("payload_bits", want.payload_bits, rpt.payload_bits);
				compare_field("data_bits", want.data_bits, rpt.data_bits);
				compare_field("direction", want.direction, rpt.direction);
				compare_field("load_minimum", want.load_minimum, rpt.load_minimum);
				compare_field("load_maximum", want.load_maximum, rpt.load_maximum);
				compare_field("average_1m", want.average_1m, rpt.average_1m);
				compare_field("average_5m", want.average_5m, rpt.average_5m);
				compare_field("average_15m", want.average_15m, rpt.average_15m);
				reports_checked++;
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((evt.valid === 1'b1 && evt.ready === 1'b1) ||
			(rpt.valid === 1'b1 && rpt.ready === 1'b1))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
			$display("** can_bus_load_monitor: FAILED **");
			$finish;
		end
	end

	// ---------------------------------------------------------------- driving

	task automatic send_word(can_word_t w);
		while ($urandom_range(99) < tx_idle_pct) begin
			evt.valid <= 1'b0;
			@(posedge clk);
		end
		evt.valid           <= 1'b1;
		evt.func            <= w.func;
		evt.frame_bits      <= w.frame_bits;
		evt.data_phase_bits <= w.data_phase_bits;
		evt.payload_len     <= w.payload_len;
		evt.is_tx           <= w.is_tx;
		do
			@(posedge clk);
		while (evt.ready !== 1'b1);
		predict_word(w);
		if (w.func != FUNC_UNUSED)
			words_sent++;
	endtask

	// drop valid, wait for every predicted report, then linger
	task automatic hold_until_drained(int extra);
		evt.valid <= 1'b0;
		@(posedge clk);
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (extra)
			@(posedge clk);
	endtask

	task automatic write_reg(cblm_reg_t idx, logic [CFG_W-1:0] val);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		@(posedge clk);
		case (idx)
			REG_NOMINAL_BR: nom_br   = val[NOM_BR_W-1:0];
			REG_DATA_BR:    data_br  = val[DATA_BR_W-1:0];
			REG_STATS_EN:   stats_on = val[0];
			default: ;
		endcase
	endtask

	// idle the block, then write all three registers; unused upper bits get noise
	task automatic apply_config(logic [NOM_BR_W-1:0] nom, logic [DATA_BR_W-1:0] dbr, logic en);
		logic [CFG_W-1:0] noise;
		hold_until_drained(SETTLE_CYCLES);
		noise = CFG_W'($urandom);
		write_reg(REG_NOMINAL_BR, {noise[CFG_W-1:NOM_BR_W], nom});
		write_reg(REG_DATA_BR, dbr);
		write_reg(REG_STATS_EN, {noise[CFG_W-1:1], en});
		wr_en <= 1'b0;
		configs_applied++;
	endtask

	function automatic can_word_t frame_word(int fb, int db, int pl, logic tx);
		can_word_t w;
		w.func            = FUNC_FRAME;
		w.frame_bits      = FBITS_W'(fb);
		w.data_phase_bits = FBITS_W'(db);
		w.payload_len     = PLEN_W'(pl);
		w.is_tx           = tx;
		return w;
	endfunction

	// non-frame word; the frame fields carry noise
	function automatic can_word_t ctrl_word(logic [FUNC_W-1:0] f);
		can_word_t w;
		w.func            = f;
		w.frame_bits      = FBITS_W'($urandom);
		w.data_phase_bits = FBITS_W'($urandom);
		w.payload_len     = PLEN_W'($urandom);
		w.is_tx           = 1'($urandom);
		return w;
	endfunction

	function automatic can_word_t random_frame();
		can_word_t w;
		w.func = FUNC_FRAME;
		w.frame_bits = ($urandom_range(3) == 0) ? FBITS_W'($urandom_range(1023))
			: FBITS_W'($urandom_range(700, 44));
		w.data_phase_bits = ($urandom_range(3) == 0) ? FBITS_W'($urandom_range(1023))
			: FBITS_W'($urandom_range(w.frame_bits));
		w.payload_len = ($urandom_range(7) == 0) ? PLEN_W'($urandom_range(127))
			: PLEN_W'($urandom_range(64));
		w.is_tx = 1'($urandom_range(1));
		return w;
	endfunction

	function automatic logic [NOM_BR_W-1:0] random_nominal();
		case ($urandom_range(5))
			0:       return '0;
			1:       return NOM_BR_W'(1);
			2:       return NOM_BR_W'($urandom_range(20000, 1));
			3:       return NOM_BR_W'($urandom);
			4:       return '1;
			default: return NOM_BR_W'($urandom_range(1000000, 100000));
		endcase
	endfunction

	function automatic logic [DATA_BR_W-1:0] random_data_br();
		case ($urandom_range(5))
			0:       return '0;
			1:       return DATA_BR_W'(1);
			2:       return DATA_BR_W'($urandom);
			3:       return '1;
			4:       return DATA_BR_W'(8000000);
			default: return DATA_BR_W'($urandom_range(8000000, 500000));
		endcase
	endfunction

	// ---------------------------------------------------------------- tests

	// ticks straight out of reset: empty second, default bitrates, stats off
	task automatic test_reset_values();
		send_word(ctrl_word(FUNC_TICK));
		send_word(ctrl_word(FUNC_TICK));
	endtask

	task automatic test_directed_frames();
		apply_config(NOM_BR_W'(500000), DATA_BR_W'(2000000), 1'b1);
		// field extremes, data bits above total bits, ignored code, both directions
		send_word(frame_word(0, 0, 0, 1'b0));
		send_word(frame_word(1023, 1023, 64, 1'b1));
		send_word(frame_word(10, 1023, 127, 1'b0));
		send_word(ctrl_word(FUNC_UNUSED));
		send_word(ctrl_word(FUNC_TICK));
		// receive only, transmit only, nothing seen
		send_word(frame_word(200, 0, 8, 1'b0));
		send_word(ctrl_word(FUNC_TICK));
		send_word(frame_word(300, 100, 32, 1'b1));
		send_word(ctrl_word(FUNC_TICK));
		send_word(ctrl_word(FUNC_TICK));
		// statistics reset takes effect at the next tick
		send_word(ctrl_word(FUNC_STATS_RST));
		send_word(frame_word(1023, 0, 64, 1'b0));
		send_word(ctrl_word(FUNC_TICK));
	endtask

	// zero nominal rate, zero data rate, smallest and largest rates
	task automatic test_bitrate_extremes();
		logic [NOM_BR_W-1:0]  noms [5];
		logic [DATA_BR_W-1:0] dbrs [5];
		logic                 ens  [5];
		noms = '{NOM_BR_W'(0), NOM_BR_W'(1), '1, NOM_BR_W'(1), NOM_BR_W'(1000000)};
		dbrs = '{DATA_BR_W'(500000), DATA_BR_W'(0), '1, DATA_BR_W'(1), DATA_BR_W'(8000000)};
		ens  = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
		for (int i = 0; i < 5; i++) begin
			apply_config(noms[i], dbrs[i], ens[i]);
			send_word(frame_word(1023, 400, 64, 1'b1));
			send_word(frame_word(600, 0, 127, 1'b0));
			send_word(ctrl_word(FUNC_TICK));
		end
	endtask

	// one long second of full-size frames at low rates, load clipped at the top
	task automatic test_long_second();
		apply_config(NOM_BR_W'(1000), DATA_BR_W'(1000), 1'b1);
		repeat (LONG_FRAMES)
			send_word(frame_word(1023, 1023, 127, 1'($urandom_range(1))));
		send_word(ctrl_word(FUNC_TICK));
	endtask

	// seconds of random frames closed by a tick, with noise, missing ticks and rate changes
	task automatic test_random_seconds(int n_words);
		int target;
		int nfr;
		target = words_sent + n_words;
		while (words_sent < target) begin
			case ($urandom_range(15))
				0, 1: apply_config(random_nominal(), random_data_br(), $urandom_range(3) != 0);
				2:    hold_until_drained(0);
				default: ;
			endcase
			nfr = ($urandom_range(11) == 0) ? $urandom_range(300) : $urandom_range(24);
			repeat (nfr) begin
				case ($urandom_range(39))
					0:       send_word(ctrl_word(FUNC_UNUSED));
					1:       send_word(ctrl_word(FUNC_STATS_RST));
					default: send_word(random_frame());
				endcase
			end
			if ($urandom_range(19) != 0)
				send_word(ctrl_word(FUNC_TICK));
		end
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		arst_n              = 1'b0;
		wr_en               = 1'b0;
		wr_index            = '0;
		wr_data             = '0;
		evt.valid           = 1'b0;
		evt.func            = '0;
		evt.frame_bits      = '0;
		evt.data_phase_bits = '0;
		evt.payload_len     = '0;
		evt.is_tx           = 1'b0;
		rpt.ready           = 1'b0;
		reset_prediction();
		repeat (8)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_directed_frames();
		test_bitrate_extremes();
		test_long_second();

		test_random_seconds(420);
		tx_idle_pct = 67;
		rx_idle_pct = 7;
		test_random_seconds(420);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		test_random_seconds(420);

		hold_until_drained(SETTLE_CYCLES);

		$display("checked %0d reports from %0d words over %0d register settings,",
			reports_checked, words_sent, configs_applied);
		$display("with zero and extreme bitrates, a long clipped second and statistics resets");
		if (errors == 0)
			$display("** can_bus_load_monitor: PASSED **");
		else
			$display("** can_bus_load_monitor: FAILED **");
		$finish;
	end

endmodule
